>>> sv/qpht_pkg.sv
// shared types and constants for the quadratic probe hash table
`default_nettype none
package qpht_pkg;
  localparam int CMD_W = 1;
  localparam int IN_KEY_W = 32;
  localparam int POS_W = 6;
  localparam int ST_W = 2;
  localparam int SIZE_W = 7;

  localparam logic [CMD_W-1:0] CMD_FIND = 1'b0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b1;

  localparam logic [ST_W-1:0] ST_PRESENT = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_NOSLOT = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd7;
  localparam int REG_TABLE_SIZE = 0;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IN_KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [ST_W-1:0] status;
  } out_word_t;
endpackage
`default_nettype wire

>>> sv/qpht_front.sv
// front end: key reduction modulo table size, one bit per cycle, into a one-word queue slot
`default_nettype none
module qpht_front #(
  parameter int KEY_WIDTH = 32,
  parameter int SZ_W = 7,
  parameter int IX_W = 6
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic full,
  input  wire qpht_pkg::in_word_t data,
  input  wire logic [SZ_W-1:0] size,
  output logic q_valid,
  input  wire logic q_take,
  output logic q_cmd,
  output logic [KEY_WIDTH-1:0] q_key,
  output logic [IX_W-1:0] q_home
);
  import qpht_pkg::*;

  localparam int CNT_W = $clog2(KEY_WIDTH + 1);
  localparam int RW = SZ_W + 1;

  logic busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic cmd_r, cmd_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] shifted, diff;
  logic qv_r, qv_nxt;
  logic qcmd_r, qcmd_nxt;
  logic [KEY_WIDTH-1:0] qkey_r, qkey_nxt;
  logic [IX_W-1:0] qhome_r, qhome_nxt;
  logic accept;

  assign full = busy_r;
  assign accept = push && !busy_r;

  always_comb begin
    shifted = {rem_r[RW-2:0], key_r[KEY_WIDTH-1]};
    diff = shifted - {1'b0, size};
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    key_nxt = key_r;
    cmd_nxt = cmd_r;
    rem_nxt = rem_r;
    qv_nxt = qv_r;
    qcmd_nxt = qcmd_r;
    qkey_nxt = qkey_r;
    qhome_nxt = qhome_r;
    if (q_take) begin
      qv_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt = CNT_W'(KEY_WIDTH);
      key_nxt = KEY_WIDTH'(data.key);
      cmd_nxt = data.cmd;
      rem_nxt = '0;
    end else if (busy_r && cnt_r != '0) begin
      rem_nxt = diff[RW-1] ? shifted : diff;
      key_nxt = {key_r[KEY_WIDTH-2:0], key_r[KEY_WIDTH-1]};
      cnt_nxt = cnt_r - 1'b1;
    end else if (busy_r && !qv_nxt) begin
      qv_nxt = 1'b1;
      qcmd_nxt = cmd_r;
      qkey_nxt = key_r;
      qhome_nxt = rem_r[IX_W-1:0];
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      qv_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      qv_r <= qv_nxt;
    end
    cnt_r <= cnt_nxt;
    key_r <= key_nxt;
    cmd_r <= cmd_nxt;
    rem_r <= rem_nxt;
    qcmd_r <= qcmd_nxt;
    qkey_r <= qkey_nxt;
    qhome_r <= qhome_nxt;
  end

  assign q_valid = qv_r;
  assign q_cmd = qcmd_r;
  assign q_key = qkey_r;
  assign q_home = qhome_r;
endmodule
`default_nettype wire

>>> sv/qpht_back.sv
// back end: probe sequencer over the cell store, with result register
`default_nettype none
module qpht_back #(
  parameter int KEY_WIDTH = 32,
  parameter int TABLE_DEPTH = 64,
  parameter int SZ_W = 7,
  parameter int IX_W = 6
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [SZ_W-1:0] size,
  input  wire logic q_valid,
  output logic q_take,
  input  wire logic q_cmd,
  input  wire logic [KEY_WIDTH-1:0] q_key,
  input  wire logic [IX_W-1:0] q_home,
  output logic empty,
  input  wire logic pop,
  output qpht_pkg::out_word_t data
);
  import qpht_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;
  localparam int CW = IX_W + 2;

  logic [1:0] st_r, st_nxt;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rd_r;
  logic vbit_r;
  logic cmd_r, cmd_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [IX_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] sum, red;
  logic wr_en;
  logic ov_r, ov_nxt;
  logic [IX_W-1:0] opos_r, opos_nxt;
  logic [ST_W-1:0] ost_r, ost_nxt;
  logic [IX_W-1:0] hpos_r, hpos_nxt;
  logic [ST_W-1:0] hst_r, hst_nxt;
  logic [CW-1:0] sz;

  // reduced step is kept below size, so one subtract wraps the sum
  always_comb begin
    sum = CW'(pos_r) + step_r;
    red = (sum >= sz) ? sum - sz : sum;
  end

  always_comb begin
    st_nxt = st_r;
    cmd_nxt = cmd_r;
    key_nxt = key_r;
    pos_nxt = pos_r;
    step_nxt = step_r;
    i_nxt = i_r;
    ov_nxt = ov_r;
    opos_nxt = opos_r;
    ost_nxt = ost_r;
    hpos_nxt = hpos_r;
    hst_nxt = hst_r;
    q_take = 1'b0;
    wr_en = 1'b0;
    if (pop && ov_r) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          cmd_nxt = q_cmd;
          key_nxt = q_key;
          pos_nxt = q_home;
          step_nxt = (sz == CW'(1)) ? '0 : CW'(1);
          i_nxt = CW'(1);
          st_nxt = S_READ;
        end
      end
      S_READ: st_nxt = S_CHECK;
      S_CHECK: begin
        if (!vbit_r) begin
          hst_nxt = ST_EMPTY;
          hpos_nxt = pos_r;
          wr_en = (cmd_r == CMD_INSERT);
          st_nxt = S_DONE;
        end else if (rd_r == key_r) begin
          hst_nxt = ST_PRESENT;
          hpos_nxt = pos_r;
          st_nxt = S_DONE;
        end else if (i_r >= sz) begin
          hst_nxt = ST_NOSLOT;
          hpos_nxt = '0;
          st_nxt = S_DONE;
        end else begin
          pos_nxt = red[IX_W-1:0];
          step_nxt = step_r + CW'(2);
          if (step_nxt >= sz) step_nxt = step_nxt - sz;
          i_nxt = i_r + 1'b1;
          st_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          opos_nxt = hpos_r;
          ost_nxt = hst_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    sz = CW'(size);
    if (size == '0) sz = CW'(1);
    if (size > SZ_W'(TABLE_DEPTH)) sz = CW'(TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[pos_r];
    vbit_r <= valid_r[pos_r];
    if (wr_en) begin
      mem[pos_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      valid_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (wr_en) valid_r[pos_r] <= 1'b1;
    end
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    pos_r <= pos_nxt;
    step_r <= step_nxt;
    i_r <= i_nxt;
    opos_r <= opos_nxt;
    ost_r <= ost_nxt;
    hpos_r <= hpos_nxt;
    hst_r <= hst_nxt;
  end

  assign empty = !ov_r;
  assign data.position = POS_W'(opos_r);
  assign data.status = ost_r;
endmodule
`default_nettype wire

>>> sv/quadratic_probe_hash_table_unit.sv
// top level of the quadratic probe hash table
`default_nettype none
// Open-addressing hash table with quadratic probing, find and insert of keys.
// In the front end an item's home cell is found by a restoring remainder, one key
// bit a cycle; the back end then spends a read state and a check state on each
// probe of the single-port cell store, plus its idle and done states. Front and back
// overlap through a one-word queue, so sustained cost is the larger of the two.
// Valid marks clear at reset; no clearing pass is needed.
module quadratic_probe_hash_table_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic in_full,
  input  wire qpht_pkg::in_word_t in_data,
  output logic out_empty,
  input  wire logic out_pop,
  output qpht_pkg::out_word_t out_data,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import qpht_pkg::*;

  localparam int IX_W = $clog2(TABLE_DEPTH);
  localparam int SZ_W = IX_W + 1;

  logic [SIZE_W-1:0] size_r;
  logic [SZ_W-1:0] size_eff;
  logic q_valid, q_take, q_cmd;
  logic [KEY_WIDTH-1:0] q_key;
  logic [IX_W-1:0] q_home;
  logic [SIZE_W:0] lim;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == 2'(REG_TABLE_SIZE * 4)) ?
                      {25'd0, size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == 2'(REG_TABLE_SIZE * 4)) begin
      size_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  // saturate and clamp to the store depth
  always_comb begin
    lim = {1'b0, size_r};
    if (lim == '0) size_eff = SZ_W'(1);
    else if (int'(lim) > TABLE_DEPTH) size_eff = SZ_W'(TABLE_DEPTH);
    else size_eff = SZ_W'(lim);
  end

  qpht_front #(.KEY_WIDTH(KEY_WIDTH), .SZ_W(SZ_W), .IX_W(IX_W)) u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .full(in_full), .data(in_data),
    .size(size_eff), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
    .q_key(q_key), .q_home(q_home)
  );

  qpht_back #(.KEY_WIDTH(KEY_WIDTH), .TABLE_DEPTH(TABLE_DEPTH),
              .SZ_W(SZ_W), .IX_W(IX_W)) u_back (
    .clk(clk), .rst_n(rst_n), .size(size_eff), .q_valid(q_valid),
    .q_take(q_take), .q_cmd(q_cmd), .q_key(q_key), .q_home(q_home),
    .empty(out_empty), .pop(out_pop), .data(out_data)
  );
endmodule
`default_nettype wire

>>> bench/tb_quadratic_probe_hash_table_unit.sv
// self-checking bench for the quadratic probe hash table: find and insert words against a predictor
module tb_quadratic_probe_hash_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import qpht_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_word_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_word_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  quadratic_probe_hash_table_unit i_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;
  logic occupied [64];
  logic [31:0] stored_key [64];
  out_word_t expected_words [$];
  in_word_t pending_words [$];
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int error_count = 0;
  logic [31:0] recent_keys [$];

  function automatic out_word_t probe_table(in_word_t w);
    int s;
    int pos;
    out_word_t r;
    s = size_reg;
    if (s == 0) s = 1;
    if (s > 64) s = 64;
    pos = w.key % s;
    r.position = '0;
    r.status = ST_NOSLOT;
    for (int i = 0; i < s; i++) begin
      if (i != 0) pos = (pos + 2 * i - 1) % s;
      if (!occupied[pos]) begin
        r.position = pos[POS_W-1:0];
        r.status = ST_EMPTY;
        if (w.cmd == CMD_INSERT) begin
          occupied[pos] = 1'b1;
          stored_key[pos] = w.key;
        end
        return r;
      end
      if (stored_key[pos] == w.key) begin
        r.position = pos[POS_W-1:0];
        r.status = ST_PRESENT;
        return r;
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        expected_words.push_back(probe_table(in_data));
        void'(pending_words.pop_front());
      end
      if ((!in_push || !in_full) && pending_words.size() > 0 &&
          !(in_push && !in_full && pending_words.size() == 0)) begin
        if (($urandom_range(99) >= send_idle_pct) &&
            !(in_push && !in_full && pending_words.size() < 1)) begin
          in_push <= 1'b1;
          in_data <= pending_words[0];
        end else begin
          in_push <= 1'b0;
        end
      end else if (!in_push || !in_full) begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word position=%0d status=%0d", out_data.position, out_data.status);
          error_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data.position !== exp_w.position) begin
            $error("position expected %0d actual %0d", exp_w.position, out_data.position);
            error_count++;
          end
          if (out_data.status !== exp_w.status) begin
            $error("status expected %0d actual %0d", exp_w.status, out_data.status);
            error_count++;
          end
        end
      end
      out_pop <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  task automatic write_size(input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'(REG_TABLE_SIZE * 4);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    size_reg = value[SIZE_W-1:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_words();
    while (pending_words.size() > 0 || in_push || expected_words.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic queue_word(input logic cmd, input logic [31:0] key);
    in_word_t w;
    w.cmd = cmd;
    w.key = key;
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] pick_key(int s);
    int sel;
    sel = $urandom_range(9);
    if (sel < 4 && recent_keys.size() > 0) return recent_keys[$urandom_range(recent_keys.size() - 1)];
    if (sel < 7) return 32'($urandom_range(4 * s));
    return $urandom();
  endfunction

  task automatic run_phase(input int count, input logic [31:0] size_value);
    logic [31:0] k;
    write_size(size_value);
    for (int n = 0; n < count; n++) begin
      k = pick_key(size_value == 0 ? 1 : (size_value > 64 ? 64 : size_value));
      if ($urandom_range(3) != 0) begin
        recent_keys.push_back(k);
        if (recent_keys.size() > 40) void'(recent_keys.pop_front());
      end
      queue_word(1'($urandom_range(1)), k);
      if (pending_words.size() > 8)
        while (pending_words.size() > 2) @(posedge clk);
    end
    drain_words();
  endtask

  initial begin
    foreach (occupied[i]) occupied[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: reset size, extremes of keys, present and empty cases, full table
    queue_word(CMD_FIND, 32'd0);
    queue_word(CMD_INSERT, 32'd0);
    queue_word(CMD_INSERT, 32'd0);
    queue_word(CMD_FIND, 32'd0);
    queue_word(CMD_INSERT, 32'hFFFF_FFFF);
    queue_word(CMD_FIND, 32'hFFFF_FFFF);
    queue_word(CMD_INSERT, 32'hAAAA_AAAA);
    queue_word(CMD_INSERT, 32'h5555_5555);
    queue_word(CMD_INSERT, 32'd7);
    queue_word(CMD_INSERT, 32'd14);
    queue_word(CMD_INSERT, 32'd21);
    queue_word(CMD_INSERT, 32'd28);
    queue_word(CMD_INSERT, 32'd35);
    queue_word(CMD_INSERT, 32'd42);
    queue_word(CMD_FIND, 32'd49);
    drain_words();
    write_size(32'd0);
    queue_word(CMD_INSERT, 32'd9);
    queue_word(CMD_FIND, 32'd3);
    drain_words();
    write_size(32'd127);
    queue_word(CMD_INSERT, 32'd63);
    queue_word(CMD_FIND, 32'd127);
    drain_words();
    send_idle_pct = 29;
    take_idle_pct = 68;
    run_phase(250, 32'd64);
    run_phase(250, 32'd1);
    send_idle_pct = 68;
    take_idle_pct = 29;
    run_phase(250, 32'd13);
    run_phase(250, 32'd8);
    send_idle_pct = 0;
    take_idle_pct = 0;
    run_phase(250, 32'd61);
    run_phase(250, 32'd100);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> files.f
sv/qpht_pkg.sv
sv/qpht_front.sv
sv/qpht_back.sv
sv/quadratic_probe_hash_table_unit.sv
bench/tb_quadratic_probe_hash_table_unit.sv
